// ===== rtl/core/tcrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcrl_pkg
// Shared constants and types for the throttle curve rate limiter.
// ----------------------------------------------------------------------------
package tcrl_pkg;

	localparam int LevelW = 14;           // level / step / limit width
	localparam int PctW   = 7;            // percent register width
	localparam int FactW  = LevelW + 1;   // twice a level
	localparam int NumW   = 27;           // dividend width, product of diff and factor
	localparam int CntW   = 5;            // divider iteration counter
	localparam int IdxW   = 3;            // configuration index width

	localparam logic [LevelW-1:0] FULL_SCALE = 14'd10000;
	localparam logic [PctW-1:0]   PCT_MAX    = 7'd100;
	localparam logic [CntW-1:0]   DIV_STEPS  = 5'd27;

	// configuration register indexes
	localparam logic [IdxW-1:0] CFG_EMPTY_POINT = 3'd0;
	localparam logic [IdxW-1:0] CFG_HALF_POINT  = 3'd1;
	localparam logic [IdxW-1:0] CFG_FULL_POINT  = 3'd2;
	localparam logic [IdxW-1:0] CFG_RISE_STEP   = 3'd3;
	localparam logic [IdxW-1:0] CFG_FALL_STEP   = 3'd4;
	localparam logic [IdxW-1:0] CFG_RAW_UPPER   = 3'd5;
	localparam logic [IdxW-1:0] CFG_RAW_LOWER   = 3'd6;

	// outcome of the classify stage
	localparam logic [1:0] KIND_FAULT = 2'd0;
	localparam logic [1:0] KIND_FULL  = 2'd1;
	localparam logic [1:0] KIND_ZERO  = 2'd2;
	localparam logic [1:0] KIND_CURVE = 2'd3;

	typedef struct packed {
		logic capture;
		logic classify;
		logic div_start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} stat_t;

endpackage

// ===== rtl/core/tcrl_div.sv =====
// ----------------------------------------------------------------------------
// tcrl_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcrl_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tcrl_pkg::NumW-1:0]         dividend,
	input  logic [tcrl_pkg::LevelW-1:0]       divisor,
	output logic                              done,
	output logic [tcrl_pkg::NumW-1:0]         quotient
);

	logic [tcrl_pkg::LevelW-1:0] rem_q;
	logic [tcrl_pkg::NumW-1:0]   quo_q;
	logic [tcrl_pkg::LevelW-1:0] dvs_q;
	logic [tcrl_pkg::CntW-1:0]   cnt_q;
	logic [tcrl_pkg::LevelW:0]   trial;
	logic                        fits;

	assign trial = {rem_q, quo_q[tcrl_pkg::NumW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= tcrl_pkg::DIV_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so it fits the level width
			rem_q <= fits ? tcrl_pkg::LevelW'(trial - {1'b0, dvs_q})
			              : trial[tcrl_pkg::LevelW-1:0];
			quo_q <= {quo_q[tcrl_pkg::NumW-2:0], fits};
		end
	end

	assign done     = (cnt_q == '0);
	assign quotient = quo_q;

endmodule

// ===== rtl/core/tcrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcrl_ctrl
// Sequencer: accept, classify, multiply, divide when needed, commit to the output word.
// ----------------------------------------------------------------------------
module tcrl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  tcrl_pkg::stat_t      stat,
	output tcrl_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLASS  = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CLASS;
			end
			ST_CLASS: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = stat.need_div ? ST_DIV : ST_COMMIT;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.classify  = (state_q == ST_CLASS);
		cmd.div_start = (state_q == ST_MUL) && stat.need_div;
		cmd.commit    = (state_q == ST_COMMIT) && slot_free;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/tcrl_dp.sv =====
// ----------------------------------------------------------------------------
// tcrl_dp
// Datapath: configuration registers, curve classification, product,
// divider and slew step with the drive state and output word.
// ----------------------------------------------------------------------------
module tcrl_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcrl_pkg::IdxW-1:0]         cfg_index,
	input  logic [tcrl_pkg::LevelW-1:0]       cfg_data,
	input  logic [tcrl_pkg::LevelW-1:0]       raw_throttle,
	input  logic                              enable_switch,
	input  tcrl_pkg::cmd_t                    cmd,
	output tcrl_pkg::stat_t                   stat,
	output logic [tcrl_pkg::LevelW-1:0]       drive_percent,
	output logic                              released,
	output logic                              config_fault
);

	// configuration
	logic [tcrl_pkg::PctW-1:0]   empty_q, half_q, full_q;
	logic [tcrl_pkg::LevelW-1:0] rise_q, fall_q, upper_q, lower_q;

	// item and state
	logic [tcrl_pkg::LevelW-1:0] raw_q;
	logic                        en_q;
	logic [tcrl_pkg::LevelW-1:0] level_q, target_q;

	// classify stage
	logic [1:0]                  kind_s1;
	logic                        rel_s1, need_div_s1;
	logic [tcrl_pkg::LevelW-1:0] diff_s1, base_s1, span_s1;
	logic [tcrl_pkg::FactW-1:0]  factor_s1;

	// output word
	logic [tcrl_pkg::LevelW-1:0] drive_q;
	logic                        rel_q, fault_q;

	// curve points
	logic [tcrl_pkg::PctW-1:0]   half_sat;
	logic [tcrl_pkg::LevelW-1:0] e_pt, f_pt, h_pt, m_pt;
	logic                        fault_w;
	logic [1:0]                  kind_w;
	logic                        rel_w, need_div_w;
	logic [tcrl_pkg::LevelW-1:0] diff_w, base_w;
	logic [tcrl_pkg::FactW-1:0]  factor_w;

	// multiply and divide
	logic [tcrl_pkg::NumW-1:0]   product;
	logic [tcrl_pkg::NumW-1:0]   quo;

	// slew
	logic [tcrl_pkg::LevelW:0]   tgt_sum;
	logic [tcrl_pkg::LevelW-1:0] tgt_w;
	logic [tcrl_pkg::LevelW:0]   up_w, fall_lim;
	logic [tcrl_pkg::LevelW-1:0] slew_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 7'd10;
			half_q  <= 7'd50;
			full_q  <= 7'd90;
			rise_q  <= 14'd100;
			fall_q  <= 14'd100;
			upper_q <= 14'd10000;
			lower_q <= 14'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcrl_pkg::CFG_EMPTY_POINT: empty_q <= cfg_data[tcrl_pkg::PctW-1:0];
				tcrl_pkg::CFG_HALF_POINT:  half_q  <= cfg_data[tcrl_pkg::PctW-1:0];
				tcrl_pkg::CFG_FULL_POINT:  full_q  <= cfg_data[tcrl_pkg::PctW-1:0];
				tcrl_pkg::CFG_RISE_STEP:   rise_q  <= cfg_data;
				tcrl_pkg::CFG_FALL_STEP:   fall_q  <= cfg_data;
				tcrl_pkg::CFG_RAW_UPPER:   upper_q <= cfg_data;
				tcrl_pkg::CFG_RAW_LOWER:   lower_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q <= raw_throttle;
			en_q  <= enable_switch;
		end
	end

	// percent points scaled to 1/10000 units
	assign half_sat = (half_q > tcrl_pkg::PCT_MAX) ? tcrl_pkg::PCT_MAX : half_q;
	assign e_pt     = tcrl_pkg::LevelW'(empty_q) * 14'd100;
	assign f_pt     = tcrl_pkg::LevelW'(full_q) * 14'd100;
	assign h_pt     = tcrl_pkg::LevelW'(half_sat) * 14'd100;
	assign m_pt     = tcrl_pkg::LevelW'({1'b0, empty_q} + {1'b0, full_q}) * 14'd50;
	assign fault_w  = (empty_q >= full_q);

	always_comb begin
		kind_w     = tcrl_pkg::KIND_CURVE;
		rel_w      = 1'b0;
		need_div_w = 1'b0;
		diff_w     = '0;
		factor_w   = '0;
		base_w     = '0;
		if (fault_w) begin
			kind_w = tcrl_pkg::KIND_FAULT;
		end else if (raw_q > upper_q) begin
			kind_w = tcrl_pkg::KIND_FULL;
		end else if (raw_q < lower_q || !en_q) begin
			kind_w = tcrl_pkg::KIND_ZERO;
			rel_w  = 1'b1;
		end else if (raw_q <= e_pt) begin
			rel_w = 1'b1;
		end else if (raw_q <= m_pt) begin
			need_div_w = 1'b1;
			diff_w     = raw_q - e_pt;
			factor_w   = {h_pt, 1'b0};
		end else if (raw_q <= f_pt) begin
			need_div_w = 1'b1;
			diff_w     = raw_q - m_pt;
			factor_w   = {tcrl_pkg::FULL_SCALE - h_pt, 1'b0};
			base_w     = h_pt;
		end else begin
			base_w = tcrl_pkg::FULL_SCALE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_div_s1 <= 1'b0;
		end else if (cmd.classify) begin
			need_div_s1 <= need_div_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			kind_s1   <= kind_w;
			rel_s1    <= rel_w;
			diff_s1   <= diff_w;
			factor_s1 <= factor_w;
			base_s1   <= base_w;
			span_s1   <= f_pt - e_pt;
		end
	end

	// product stays below 2^27: diff is at most half the span
	assign product = tcrl_pkg::NumW'(diff_s1) * tcrl_pkg::NumW'(factor_s1);

	tcrl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (product),
		.divisor  (span_s1),
		.done     (stat.div_done),
		.quotient (quo)
	);

	assign stat.need_div = need_div_s1;

	// target, then the slew step towards it
	assign tgt_sum = {1'b0, base_s1} + {1'b0, quo[tcrl_pkg::LevelW-1:0]};

	always_comb begin
		if (!need_div_s1) begin
			tgt_w = base_s1;
		end else if (tgt_sum > {1'b0, tcrl_pkg::FULL_SCALE}) begin
			tgt_w = tcrl_pkg::FULL_SCALE;
		end else begin
			tgt_w = tgt_sum[tcrl_pkg::LevelW-1:0];
		end
	end

	assign up_w     = {1'b0, level_q} + {1'b0, rise_q};
	assign fall_lim = {1'b0, tgt_w} + {1'b0, fall_q};

	always_comb begin
		if (tgt_w > level_q) begin
			slew_w = (up_w > {1'b0, tgt_w}) ? tgt_w : up_w[tcrl_pkg::LevelW-1:0];
		end else if (tgt_w < level_q) begin
			slew_w = ({1'b0, level_q} < fall_lim) ? tgt_w : level_q - fall_q;
		end else begin
			slew_w = level_q;
		end
		if (slew_w > tcrl_pkg::FULL_SCALE) slew_w = tcrl_pkg::FULL_SCALE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			target_q <= '0;
		end else if (cmd.commit) begin
			case (kind_s1)
				tcrl_pkg::KIND_FAULT: begin
					level_q  <= '0;
					target_q <= '0;
				end
				tcrl_pkg::KIND_FULL: begin
					level_q <= tcrl_pkg::FULL_SCALE;
				end
				tcrl_pkg::KIND_ZERO: begin
					level_q <= '0;
				end
				default: begin
					level_q  <= slew_w;
					target_q <= tgt_w;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (kind_s1)
				tcrl_pkg::KIND_FAULT: drive_q <= '0;
				tcrl_pkg::KIND_FULL:  drive_q <= tcrl_pkg::FULL_SCALE;
				tcrl_pkg::KIND_ZERO:  drive_q <= '0;
				default:              drive_q <= slew_w;
			endcase
			rel_q   <= rel_s1;
			fault_q <= (kind_s1 == tcrl_pkg::KIND_FAULT);
		end
	end

	assign drive_percent = drive_q;
	assign released      = rel_q;
	assign config_fault  = fault_q;

endmodule

// ===== rtl/core/throttle_curve_rate_limiter_core.sv =====
// ----------------------------------------------------------------------------
// throttle_curve_rate_limiter_core
// Throttle curve with slew-rate limited drive output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one control tick: raw_throttle
//   and enable_switch. Output channel (out_valid / out_stall) returns one word
//   per tick: drive_percent, released and config_fault.
//   Configuration is written through cfg_we / cfg_index / cfg_data; the user
//   must write it only while idle, as the block does not enforce this;
//   unknown indexes are ignored. Ticks on the curve segments pass through
//   the 27-step radix-2 divider before out_valid; no division is needed
//   for a fault, forced full or zero, below the empty point or above the
//   full point. One tick is processed at a time: the next is not accepted
//   until the last has committed. The output word sits in its own register,
//   so the next tick is accepted while the last word waits; if the receiver
//   stalls, a finished tick holds in the commit step until the output
//   register frees up. Reset clears the drive level and target to zero,
//   loads the default curve and limits, and empties the output register.
// ----------------------------------------------------------------------------
module throttle_curve_rate_limiter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcrl_pkg::IdxW-1:0]         cfg_index,
	input  logic [tcrl_pkg::LevelW-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tcrl_pkg::LevelW-1:0]       raw_throttle,
	input  logic                              enable_switch,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcrl_pkg::LevelW-1:0]       drive_percent,
	output logic                              released,
	output logic                              config_fault
);

	tcrl_pkg::cmd_t  cmd;
	tcrl_pkg::stat_t stat;

	tcrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcrl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.raw_throttle  (raw_throttle),
		.enable_switch (enable_switch),
		.cmd           (cmd),
		.stat          (stat),
		.drive_percent (drive_percent),
		.released      (released),
		.config_fault  (config_fault)
	);

endmodule

// ===== rtl/core/tcrl_chk.sv =====
// ----------------------------------------------------------------------------
// tcrl_chk
// Port-level checks for the throttle curve rate limiter, bound to the core.
// ----------------------------------------------------------------------------
module tcrl_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [tcrl_pkg::LevelW-1:0]       drive_percent,
	input  logic                              released,
	input  logic                              config_fault
);

	// one tick at a time: after acceptance the input side closes
	a_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a tick was in flight");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_percent <= tcrl_pkg::FULL_SCALE)
		else $error("drive word above full scale");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_fault |-> drive_percent == '0 && !released)
		else $error("faulted word carries drive or release");

	// a fresh word needs an earlier accepted tick, with the input side closed while it was processed
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_stall, 1) && $past(in_stall, 3))
		else $error("output word appeared without a processed tick");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_percent))
		else $error("stalled output word changed");

endmodule

bind throttle_curve_rate_limiter_core tcrl_chk u_tcrl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.drive_percent (drive_percent),
	.released      (released),
	.config_fault  (config_fault)
);
